[rtl/btms_pkg.sv]
// Package: shared widths, register codes, reset values and payload types.
`default_nettype none
package btms_pkg;

  localparam int PIX_W          = 8;
  localparam int LABEL_W        = 8;
  localparam int HITS_W         = 17;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 8;
  localparam int MAX_PIXELS_DEF = 65536;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_THRESHOLD = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_NO_MATCH_LABEL  = CFG_IDX_W'(1);

  // reset values
  localparam logic [PIX_W-1:0]   THRESHOLD_RST = PIX_W'(127);
  localparam logic [LABEL_W-1:0] NO_MATCH_RST  = LABEL_W'(64);

  typedef struct packed {
    logic [PIX_W-1:0]   pixel_threshold;
    logic [LABEL_W-1:0] no_match_label;
  } cfg_t;

  typedef struct packed {
    logic [PIX_W-1:0]   candidate_pixel;
    logic [PIX_W-1:0]   reference_pixel;
    logic [LABEL_W-1:0] reference_label;
    logic               last_of_template;
    logic               last_of_set;
  } item_t;

  typedef struct packed {
    logic [LABEL_W-1:0] best_label;
    logic [HITS_W-1:0]  best_hits;
  } res_t;

endpackage
`default_nettype wire

[rtl/btms_if.sv]
// Interfaces: pixel-pair input channel and result output channel.
`default_nettype none
interface btms_pix_if;
  logic                        valid;
  logic                        ready;
  logic [btms_pkg::PIX_W-1:0]   candidate_pixel;
  logic [btms_pkg::PIX_W-1:0]   reference_pixel;
  logic [btms_pkg::LABEL_W-1:0] reference_label;
  logic                        last_of_template;
  logic                        last_of_set;

  modport source (
    output valid, candidate_pixel, reference_pixel, reference_label,
           last_of_template, last_of_set,
    input  ready
  );
  modport sink (
    input  valid, candidate_pixel, reference_pixel, reference_label,
           last_of_template, last_of_set,
    output ready
  );
endinterface

interface btms_res_if;
  logic                        valid;
  logic                        ready;
  logic [btms_pkg::LABEL_W-1:0] best_label;
  logic [btms_pkg::HITS_W-1:0]  best_hits;

  modport source (output valid, best_label, best_hits, input ready);
  modport sink (input valid, best_label, best_hits, output ready);
endinterface
`default_nettype wire

[rtl/btms_cfg_regs.sv]
// Configuration registers: pixel threshold and no-match label.
`default_nettype none
module btms_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           wr_en,
  input  wire logic [btms_pkg::CFG_IDX_W-1:0]  wr_index,
  input  wire logic [btms_pkg::CFG_DATA_W-1:0] wr_data,
  output btms_pkg::cfg_t                       cfg
);

  btms_pkg::cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.pixel_threshold <= btms_pkg::THRESHOLD_RST;
      regs.no_match_label  <= btms_pkg::NO_MATCH_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        btms_pkg::REG_PIXEL_THRESHOLD: begin
          regs.pixel_threshold <= wr_data[btms_pkg::PIX_W-1:0];
        end
        btms_pkg::REG_NO_MATCH_LABEL: begin
          regs.no_match_label <= wr_data[btms_pkg::LABEL_W-1:0];
        end
        default: ; // unmapped index: ignored
      endcase
    end
  end

  assign cfg = regs;

endmodule
`default_nettype wire

[rtl/btms_match_core.sv]
// Match core: per-template counters, acceptance test and best-match tracking.
`default_nettype none
module btms_match_core #(
  parameter int MAX_PIXELS = btms_pkg::MAX_PIXELS_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire btms_pkg::cfg_t  cfg,
  input  wire logic    step,
  input  wire btms_pkg::item_t item,
  output btms_pkg::res_t  res
);

  localparam int CNT_W = $clog2(MAX_PIXELS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PIXELS);
  localparam int HITS_W = btms_pkg::HITS_W;

  logic [CNT_W-1:0]             hit_count, hit_count_next;
  logic [CNT_W-1:0]             set_count, set_count_next;
  logic [CNT_W-1:0]             best_count, best_count_next;
  logic [btms_pkg::LABEL_W-1:0] best_label, best_label_next;

  logic               ref_set, cand_set, close, take;
  logic [CNT_W-1:0]   hit_upd, set_upd;
  logic [CNT_W+1:0]   hits_x4, set_x3;
  logic [CNT_W+HITS_W-1:0] hits_ext;

  always_comb begin
    ref_set  = item.reference_pixel > cfg.pixel_threshold;
    cand_set = item.candidate_pixel > cfg.pixel_threshold;
    // saturating counts including this pixel
    set_upd = set_count + CNT_W'(ref_set && (set_count != CNT_MAX));
    hit_upd = hit_count + CNT_W'(ref_set && cand_set && (hit_count != CNT_MAX));
    close   = item.last_of_template | item.last_of_set;

    hits_x4 = {hit_upd, 2'b00};
    set_x3  = {2'b00, set_upd} + {1'b0, set_upd, 1'b0};
    // strictly better than best, and over 3/4 of the set pixels
    take = close && (hit_upd > best_count) && (hits_x4 > set_x3);

    best_count_next = take ? hit_upd : best_count;
    best_label_next = take ? item.reference_label : best_label;

    hits_ext = {{HITS_W{1'b0}}, best_count_next};
    if (best_count_next != '0) begin
      res.best_label = best_label_next;
      res.best_hits  = hits_ext[HITS_W-1:0];
    end else begin
      res.best_label = cfg.no_match_label;
      res.best_hits  = '0;
    end

    hit_count_next = close ? '0 : hit_upd;
    set_count_next = close ? '0 : set_upd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_count  <= '0;
      set_count  <= '0;
      best_count <= '0;
      best_label <= btms_pkg::NO_MATCH_RST;
    end else if (step) begin
      hit_count <= hit_count_next;
      set_count <= set_count_next;
      if (item.last_of_set) begin
        best_count <= '0;
        best_label <= cfg.no_match_label;
      end else begin
        best_count <= best_count_next;
        best_label <= best_label_next;
      end
    end
  end

`ifndef SYNTHESIS
  a_hits_le_set: assert property (@(posedge clk) disable iff (rst)
    hit_count <= set_count)
    else $error("hit count exceeds set count");

  a_close_clears: assert property (@(posedge clk) disable iff (rst)
    step && close |=> hit_count == '0 && set_count == '0)
    else $error("counters not cleared at template end");

  a_set_end_clears_best: assert property (@(posedge clk) disable iff (rst)
    step && item.last_of_set |=> best_count == '0)
    else $error("best count not cleared at set end");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    set_count <= CNT_MAX && best_count <= CNT_MAX)
    else $error("count above saturation bound");
`endif

endmodule
`default_nettype wire

[rtl/binary_template_match_select_core.sv]
// Top level: binary template matching with best-match selection.
//
// Usage:
//   pix    - input channel, one candidate/template pixel pair per transfer.
//            Templates follow one another; last_of_template closes one,
//            last_of_set closes the final template and the whole set.
//   result - output channel, one transfer per set (on last_of_set) carrying
//            the best accepted template's label and hit count, or the
//            no-match label with zero hits.
//   wr_*   - register writes (threshold, no-match label), only while idle.
// Throughput: one pixel pair per cycle outside a stall, set by the single
//   compare/count/accept stage between the input and result registers.
// Result path: the last_of_set pair sits in the input register, and the
//   result register captures its result when that pair advances.
// Stall: while a result waits on result.ready, pixel pairs that close no
//   set keep flowing; the next set-closing pair waits in the input register
//   and pix.ready drops behind it.
// Reset (rst, synchronous): counters and best match clear, registers return
//   to threshold 127 and no-match label 64, both channels empty.
`default_nettype none
module binary_template_match_select_core #(
  parameter int MAX_PIXELS = btms_pkg::MAX_PIXELS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           wr_en,
  input  wire logic [btms_pkg::CFG_IDX_W-1:0]  wr_index,
  input  wire logic [btms_pkg::CFG_DATA_W-1:0] wr_data,
  btms_pix_if.sink                            pix,
  btms_res_if.source                          result
);

  btms_pkg::cfg_t  cfg;
  btms_pkg::item_t item_q;
  btms_pkg::res_t  res_comb, res_q;
  logic            item_valid;
  logic            res_valid;
  logic            advance;

  btms_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  // Input register advances unless it holds a set-closing pair and the
  // result register is still occupied and not taken by result.ready.
  assign advance   = item_valid &&
                     (!item_q.last_of_set || !res_valid || result.ready);
  assign pix.ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (pix.ready) begin
      item_valid <= pix.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pix.ready && pix.valid) begin
      item_q.candidate_pixel  <= pix.candidate_pixel;
      item_q.reference_pixel  <= pix.reference_pixel;
      item_q.reference_label  <= pix.reference_label;
      item_q.last_of_template <= pix.last_of_template;
      item_q.last_of_set      <= pix.last_of_set;
    end
  end

  btms_match_core #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .step (advance),
    .item (item_q),
    .res  (res_comb)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance && item_q.last_of_set) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item_q.last_of_set) begin
      res_q <= res_comb;
    end
  end

  assign result.valid      = res_valid;
  assign result.best_label = res_q.best_label;
  assign result.best_hits  = res_q.best_hits;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_valid && !result.ready |=> res_valid && $stable(res_q))
    else $error("pending result overwritten or dropped");

  a_stall_holds_item: assert property (@(posedge clk) disable iff (rst)
    item_valid && !advance |=> item_valid && $stable(item_q))
    else $error("stalled input item lost");

  a_result_from_set_end: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(advance && item_q.last_of_set))
    else $error("result without a set-closing transfer");
`endif

endmodule
`default_nettype wire

[dv/tb_binary_template_match_select_core.sv]
// Testbench: template best-match selection checked against an in-bench scoring model.
module tb_binary_template_match_select_core;
  import btms_pkg::*;

  localparam int HALF_PERIOD            = 6;
  localparam int RESET_CYCLES           = 7;
  // Result goes through the input, then the result register; add margin.
  localparam int RESULT_LATENCY         = 1;
  localparam int SETTLE_CYCLES          = RESULT_LATENCY + 2;
  // Longest legal quiet stretch is the long result hold-off below.
  localparam int QUIET_LIMIT            = 2000;
  localparam int HOLD_OFF_CYCLES        = 300;
  localparam int MAX_REPORTS            = 10;
  localparam int RANDOM_ITEMS_PER_PHASE = 330;
  localparam int BURST_SETS             = 60;
  localparam int LONG_TEMPLATE_LEN      = 100;

  // Indexes past the register list; writes there must be dropped.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = CFG_IDX_W'(3);

  localparam logic [HITS_W-1:0] PIXEL_CAP = HITS_W'(MAX_PIXELS_DEF);

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  wr_en    = 1'b0;
  logic [CFG_IDX_W-1:0]  wr_index = '0;
  logic [CFG_DATA_W-1:0] wr_data  = '0;

  btms_pix_if pix_if ();
  btms_res_if res_if ();

  binary_template_match_select_core u_top (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .pix      (pix_if),
    .result   (res_if)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Scoring model: register copies, per-template counters, best of the set
  // ---------------------------------------------------------------------
  logic [PIX_W-1:0]   model_threshold;
  logic [LABEL_W-1:0] model_no_match;
  logic [HITS_W-1:0]  tpl_hits;
  logic [HITS_W-1:0]  tpl_set;
  logic [HITS_W-1:0]  set_best_hits;
  logic [LABEL_W-1:0] set_best_label;

  // Best-match results owed by the block, oldest first.
  res_t expected_matches[$];

  int mismatches    = 0;
  int quiet_cycles  = 0;
  int src_idle_pct  = 0;
  int snk_stall_pct = 0;
  bit holding       = 1'b0;
  event hold_off_start;

  function automatic void model_reset();
    model_threshold = THRESHOLD_RST;
    model_no_match  = NO_MATCH_RST;
    tpl_hits        = '0;
    tpl_set         = '0;
    set_best_hits   = '0;
    set_best_label  = NO_MATCH_RST;
  endfunction

  // Counters stick at the pixel cap instead of wrapping.
  function automatic logic [HITS_W-1:0] bump(logic [HITS_W-1:0] v);
    return (v < PIXEL_CAP) ? v + 1'b1 : PIXEL_CAP;
  endfunction

  // Scores one accepted pixel pair; a set-closing pair owes one result.
  function automatic void score_pixel_pair(item_t pp);
    logic [HITS_W+1:0] hits4;
    logic [HITS_W+1:0] set3;
    res_t              outcome;
    if (pp.reference_pixel > model_threshold) begin
      tpl_set = bump(tpl_set);
      if (pp.candidate_pixel > model_threshold) tpl_hits = bump(tpl_hits);
    end
    // set end closes the open template even without last_of_template
    if (pp.last_of_template || pp.last_of_set) begin
      hits4 = {tpl_hits, 2'b00};
      set3  = (HITS_W+2)'(tpl_set) * (HITS_W+2)'(3);
      // strict compare: a tie keeps the earlier template
      if (tpl_hits > set_best_hits && hits4 > set3) begin
        set_best_hits  = tpl_hits;
        set_best_label = pp.reference_label;
      end
      tpl_hits = '0;
      tpl_set  = '0;
    end
    if (pp.last_of_set) begin
      if (set_best_hits != '0) begin
        outcome.best_label = set_best_label;
        outcome.best_hits  = set_best_hits;
      end else begin
        outcome.best_label = model_no_match;
        outcome.best_hits  = '0;
      end
      expected_matches.push_back(outcome);
      set_best_hits  = '0;
      set_best_label = model_no_match;
    end
  endfunction

  // ---------------------------------------------------------------------
  // Input side: all tasks start and end just after a falling edge
  // ---------------------------------------------------------------------
  task automatic send_pair(input item_t pp);
    while ($urandom_range(99) < src_idle_pct) begin
      pix_if.valid <= 1'b0;
      @(negedge clk);
    end
    pix_if.valid            <= 1'b1;
    pix_if.candidate_pixel  <= pp.candidate_pixel;
    pix_if.reference_pixel  <= pp.reference_pixel;
    pix_if.reference_label  <= pp.reference_label;
    pix_if.last_of_template <= pp.last_of_template;
    pix_if.last_of_set      <= pp.last_of_set;
    @(posedge clk);
    while (!pix_if.ready) @(posedge clk);
    score_pixel_pair(pp);
    @(negedge clk);
  endtask

  task automatic send_pix(input logic [PIX_W-1:0] cand, input logic [PIX_W-1:0] tpl_px,
                          input logic [LABEL_W-1:0] label, input logic eot, input logic eos);
    item_t pp;
    pp.candidate_pixel  = cand;
    pp.reference_pixel  = tpl_px;
    pp.reference_label  = label;
    pp.last_of_template = eot;
    pp.last_of_set      = eos;
    send_pair(pp);
  endtask

  // Drop valid, wait for every owed result, then let the pipeline settle
  // (trailing pairs that close no set may still be in flight).
  task automatic wait_idle();
    pix_if.valid <= 1'b0;
    while (expected_matches.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    wait_idle();
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    case (idx)
      REG_PIXEL_THRESHOLD: model_threshold = data;
      REG_NO_MATCH_LABEL:  model_no_match  = data;
      default: ;
    endcase
    @(negedge clk);
    wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // Pixel value on the requested side of the current threshold, sometimes
  // fully random so every bit toggles regardless of threshold.
  function automatic logic [PIX_W-1:0] pick_pixel(bit want_set);
    if ($urandom_range(7) == 0) return PIX_W'($urandom_range(255));
    if (want_set && model_threshold != 8'hFF)
      return PIX_W'($urandom_range(255, int'(model_threshold) + 1));
    if (!want_set) return PIX_W'($urandom_range(int'(model_threshold), 0));
    return PIX_W'($urandom_range(255));
  endfunction

  // Mostly well-formed sets of a few short templates; about one pick in ten
  // sends a single noise transfer with random flags instead.
  task automatic send_random_sets(input int n_items);
    int    sent;
    int    n_tpl;
    int    len;
    item_t pp;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) == 0) begin
        pp.candidate_pixel  = PIX_W'($urandom_range(255));
        pp.reference_pixel  = PIX_W'($urandom_range(255));
        pp.reference_label  = LABEL_W'($urandom_range(255));
        pp.last_of_template = 1'($urandom_range(1));
        pp.last_of_set      = 1'($urandom_range(1));
        send_pair(pp);
        sent++;
      end else begin
        n_tpl = $urandom_range(1, 4);
        for (int t = 0; t < n_tpl; t++) begin
          pp.reference_label = LABEL_W'($urandom_range(255));
          len = $urandom_range(1, 10);
          for (int p = 0; p < len; p++) begin
            pp.reference_pixel = pick_pixel($urandom_range(99) < 60);
            // candidate mostly follows the template so matches happen
            pp.candidate_pixel = pick_pixel(($urandom_range(99) < 80) ?
                                            (pp.reference_pixel > model_threshold) :
                                            1'($urandom_range(1)));
            pp.last_of_template = 1'b0;
            pp.last_of_set      = 1'b0;
            if (p == len - 1) begin
              pp.last_of_set      = (t == n_tpl - 1);
              // final template may close on last_of_set alone
              pp.last_of_template = (t != n_tpl - 1) || 1'($urandom_range(1));
            end
            send_pair(pp);
            sent++;
          end
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Output side
  // ---------------------------------------------------------------------
  always @(negedge clk) res_if.ready <= !holding && ($urandom_range(99) >= snk_stall_pct);

  // Long hold-off on the result channel, counted here in clock cycles.
  always begin
    @(hold_off_start);
    @(posedge clk);
    holding = 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk);
    holding = 1'b0;
  end

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("ERROR: %s", what);
  endtask

  always @(posedge clk) begin : check_results
    res_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      if (expected_matches.size() == 0) begin
        note_mismatch($sformatf("unexpected result label %0d hits %0d",
                                res_if.best_label, res_if.best_hits));
      end else begin
        want = expected_matches.pop_front();
        if (res_if.best_label !== want.best_label)
          note_mismatch($sformatf("best_label expected %0d got %0d",
                                  want.best_label, res_if.best_label));
        if (res_if.best_hits !== want.best_hits)
          note_mismatch($sformatf("best_hits expected %0d got %0d",
                                  want.best_hits, res_if.best_hits));
      end
    end
  end

  // Watchdog: too many cycles without any transfer ends the run.
  always @(posedge clk) begin
    if (rst || (pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Reset threshold 127: pixel extremes, accept, tie, 4h == 3s reject,
  // set end without template end, empty match, single-pixel set.
  task automatic test_directed_cases();
    // template 0x41: 2 set, 2 hits -> accepted
    send_pix(8'hFF, 8'hFF, 8'h41, 1'b0, 1'b0);
    send_pix(8'h80, 8'h80, 8'h41, 1'b0, 1'b0);
    send_pix(8'h00, 8'h00, 8'h41, 1'b1, 1'b0);
    // template 0xFF: same hits -> tie, earlier stays
    send_pix(8'hC8, 8'hFF, 8'hFF, 1'b0, 1'b0);
    send_pix(8'hFF, 8'h82, 8'hFF, 1'b1, 1'b0);
    // template 0x00: 3 hits of 4 set, 12 > 12 fails; closed by set end only
    send_pix(8'hFF, 8'hFF, 8'h00, 1'b0, 1'b0);
    send_pix(8'hFF, 8'hFF, 8'h00, 1'b0, 1'b0);
    send_pix(8'h7F, 8'hFF, 8'h00, 1'b0, 1'b0);
    send_pix(8'hFF, 8'hFF, 8'h00, 1'b0, 1'b1);
    // nothing set anywhere -> no-match label, zero hits
    send_pix(8'h7F, 8'h7F, 8'h22, 1'b1, 1'b0);
    send_pix(8'hFF, 8'h00, 8'h23, 1'b0, 1'b1);
    // single pixel closing template and set together
    send_pix(8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1);
    // later template with more hits wins
    send_pix(8'hFF, 8'hFF, 8'h10, 1'b1, 1'b0);
    send_pix(8'hFF, 8'hFF, 8'hEF, 1'b0, 1'b0);
    send_pix(8'h81, 8'hFE, 8'hEF, 1'b1, 1'b1);
    wait_idle();
  endtask

  task automatic test_register_extremes();
    // threshold 255: no pixel can be set
    write_register(REG_PIXEL_THRESHOLD, 8'hFF);
    send_pix(8'hFF, 8'hFF, 8'hAA, 1'b0, 1'b0);
    send_pix(8'hFF, 8'hFF, 8'h55, 1'b1, 1'b1);
    // threshold 0, no-match 0
    write_register(REG_PIXEL_THRESHOLD, 8'h00);
    write_register(REG_NO_MATCH_LABEL, 8'h00);
    send_pix(8'h01, 8'h01, 8'h3C, 1'b1, 1'b0);
    send_pix(8'h00, 8'hFF, 8'hC3, 1'b0, 1'b1);
    send_pix(8'h00, 8'h00, 8'h99, 1'b1, 1'b1);
    write_register(REG_NO_MATCH_LABEL, 8'hFF);
    send_pix(8'h00, 8'h00, 8'h12, 1'b1, 1'b1);
    // writes past the register list must not disturb either register
    write_register(REG_SPARE_2, 8'h00);
    write_register(REG_SPARE_3, 8'hFF);
    write_register(REG_SPARE_2, 8'h55);
    send_pix(8'h01, 8'h01, 8'h7E, 1'b1, 1'b1);
    send_pix(8'h00, 8'h00, 8'h7E, 1'b1, 1'b1);
    wait_idle();
  endtask

  // One template far longer than the random ones, every pixel set and hit,
  // after a short winner that it must displace.
  task automatic test_long_template();
    write_register(REG_PIXEL_THRESHOLD, 8'h00);
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    send_pix(8'h01, 8'h01, 8'h01, 1'b0, 1'b0);
    send_pix(8'h01, 8'h01, 8'h01, 1'b1, 1'b0);
    for (int i = 0; i < LONG_TEMPLATE_LEN; i++)
      send_pix(8'hFF, 8'hFF, 8'h5A, 1'b0, 1'b0);
    send_pix(8'hFF, 8'hFF, 8'h5A, 1'b1, 1'b1);
    wait_idle();
  endtask

  // Random sets under each idling profile, fresh registers per phase.
  task automatic test_random_phases();
    int src_pct[4];
    int snk_pct[4];
    src_pct = '{0, 86, 0, 15};
    snk_pct = '{0, 0, 86, 15};
    for (int ph = 0; ph < 4; ph++) begin
      write_register(REG_PIXEL_THRESHOLD, CFG_DATA_W'($urandom_range(1, 254)));
      write_register(REG_NO_MATCH_LABEL, CFG_DATA_W'($urandom_range(255)));
      src_idle_pct  = src_pct[ph];
      snk_stall_pct = snk_pct[ph];
      send_random_sets(RANDOM_ITEMS_PER_PHASE);
    end
    wait_idle();
  endtask

  // Result channel held off while single-pixel sets keep coming: block
  // fills, pix.ready drops; then the sender waits for every result.
  task automatic test_result_backpressure();
    write_register(REG_PIXEL_THRESHOLD, THRESHOLD_RST);
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    -> hold_off_start;
    for (int i = 0; i < BURST_SETS; i++)
      send_pix(PIX_W'($urandom_range(255)), PIX_W'($urandom_range(255)),
               LABEL_W'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
    wait_idle();
    snk_stall_pct = 50;
    send_random_sets(40);
    wait_idle();
  endtask

  initial begin
    pix_if.valid            = 1'b0;
    pix_if.candidate_pixel  = '0;
    pix_if.reference_pixel  = '0;
    pix_if.reference_label  = '0;
    pix_if.last_of_template = 1'b0;
    pix_if.last_of_set      = 1'b0;
    res_if.ready            = 1'b0;
    model_reset();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_register_extremes();
    test_long_template();
    test_random_phases();
    test_result_backpressure();

    // all owed results in, plus pipeline settle
    wait_idle();
    if (mismatches == 0 && expected_matches.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[binary_template_match_select_core.f]
rtl/btms_pkg.sv
rtl/btms_if.sv
rtl/btms_cfg_regs.sv
rtl/btms_match_core.sv
rtl/binary_template_match_select_core.sv
dv/tb_binary_template_match_select_core.sv
